// ===== hdl/slsa_pkg.sv =====
`default_nettype none

package slsa_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 4;
  localparam int unsigned SLOT_BYTES_DEF = 128;

  // The line store is split into four byte banks so that a closing beat can
  // write CR, LF and the terminating zero together.
  localparam int unsigned BANKS  = 4;
  localparam int unsigned BANK_W = 2;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_WRITING = 2'd1,
    ST_READY   = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [1:0] slot_select;
    logic [6:0] byte_offset;
  } in_beat_t;

  typedef struct packed {
    logic       line_done;
    logic [1:0] done_slot;
    logic [6:0] done_length;
    logic       truncated;
    logic [7:0] read_data;
    logic [1:0] read_status;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== hdl/slsa_chan_if.sv =====
`default_nettype none

interface slsa_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== hdl/slsa_line_store.sv =====
`default_nettype none

module slsa_line_store import slsa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int unsigned SLOT_BYTES = SLOT_BYTES_DEF,
  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT),
  localparam int unsigned POS_W  = $clog2(SLOT_BYTES) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [BANKS-1:0]              wr_en_i,
  input  logic [SLOT_W-1:0]             wr_slot_i,
  input  logic [BANKS-1:0][POS_W-1:0]   wr_pos_i,
  input  logic [BANKS-1:0][7:0]         wr_data_i,
  input  logic                          rd_ok_i,
  input  logic [SLOT_W-1:0]             rd_slot_i,
  input  logic [POS_W-1:0]              rd_pos_i,
  output logic [7:0]                    rd_data_o,
  output logic                          busy_o
);

  localparam int unsigned RPS   = (SLOT_BYTES + BANKS - 1) / BANKS;
  localparam int unsigned ROWS  = SLOT_COUNT * RPS;
  localparam int unsigned ROW_W = $clog2(ROWS);

  logic [BANKS-1:0][ROW_W-1:0] wr_row;
  logic [ROW_W-1:0]            rd_row;
  logic [7:0]                  bank_rd [BANKS];
  logic [BANK_W-1:0]           rd_bank_q;
  logic                        rd_ok_q;
  logic                        clr_q;
  logic [ROW_W-1:0]            cnt_q;

  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      wr_row[b] = ROW_W'(wr_slot_i) * ROW_W'(RPS) + ROW_W'(wr_pos_i[b] >> BANK_W);
    end
    rd_row = ROW_W'(rd_slot_i) * ROW_W'(RPS) + ROW_W'(rd_pos_i >> BANK_W);
  end

  // After reset every row of every bank is cleared once, one row per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else if (clr_q) begin
      if (cnt_q == ROW_W'(ROWS - 1)) begin
        clr_q <= 1'b0;
      end
      cnt_q <= cnt_q + ROW_W'(1);
    end
  end

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [7:0] mem [ROWS];
    logic [7:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (clr_q) begin
        mem[cnt_q] <= '0;
      end else if (wr_en_i[b]) begin
        mem[wr_row[b]] <= wr_data_i[b];
      end
      if (step_i) begin
        rd_q <= mem[rd_row];
      end
    end

    assign bank_rd[b] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q   <= 1'b0;
      rd_bank_q <= '0;
    end else if (step_i) begin
      rd_ok_q   <= rd_ok_i;
      rd_bank_q <= rd_pos_i[BANK_W-1:0];
    end
  end

  assign rd_data_o = rd_ok_q ? bank_rd[rd_bank_q] : 8'h00;
  assign busy_o    = clr_q;

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_q |=> !clr_q)
    else $error("Clearing pass restarted without reset.");

  a_no_step_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !step_i && (wr_en_i == '0))
    else $error("Beat processed during the clearing pass.");

  a_read_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(rd_ok_q) && $stable(rd_bank_q))
    else $error("Read result changed without a step.");

endmodule

`default_nettype wire

// ===== hdl/slsa_slot_ctrl.sv =====
`default_nettype none

module slsa_slot_ctrl import slsa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int unsigned SLOT_BYTES = SLOT_BYTES_DEF,
  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT),
  localparam int unsigned IDX_W  = $clog2(SLOT_BYTES),
  localparam int unsigned POS_W  = IDX_W + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  in_beat_t                      item_i,
  output logic [BANKS-1:0]              wr_en_o,
  output logic [SLOT_W-1:0]             wr_slot_o,
  output logic [BANKS-1:0][POS_W-1:0]   wr_pos_o,
  output logic [BANKS-1:0][7:0]         wr_data_o,
  output logic                          rd_ok_o,
  output logic [SLOT_W-1:0]             rd_slot_o,
  output logic [POS_W-1:0]              rd_pos_o,
  output out_beat_t                     res_o
);

  status_e           status_q [SLOT_COUNT];
  status_e           status_d [SLOT_COUNT];
  logic [IDX_W-1:0]  wi_q, wi_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [SLOT_W-1:0] nxt;
  logic [SLOT_W-1:0] sel_slot;
  logic              sel_ok;
  logic              off_ok;
  logic [POS_W-1:0]  wi_ext;
  logic [POS_W-1:0]  dlen;
  logic [1:0]        nbytes;
  logic [7:0]        bytes [3];
  logic              close;
  logic              trunc;

  assign sel_slot = SLOT_W'(item_i.slot_select);
  assign sel_ok   = item_i.slot_select < SLOT_COUNT;
  assign off_ok   = item_i.byte_offset < SLOT_BYTES;
  assign wi_ext   = POS_W'(wi_q);
  assign nxt      = (cur_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : cur_q + SLOT_W'(1);

  always_comb begin
    status_d = status_q;
    wi_d     = wi_q;
    cur_d    = cur_q;
    nbytes   = 2'd0;
    bytes    = '{default: CH_NUL};
    close    = 1'b0;
    trunc    = 1'b0;
    dlen     = '0;
    res_o    = '0;

    case (item_i.kind)
      KIND_BYTE: begin
        if (item_i.data_byte == CH_LF) begin
          if (wi_q < SLOT_BYTES - 1) begin
            nbytes   = 2'd2;
            bytes[0] = CH_LF;
            bytes[1] = CH_NUL;
            dlen     = wi_ext + POS_W'(1);
          end else begin
            nbytes   = 2'd1;
            bytes[0] = CH_NUL;
            dlen     = wi_ext;
          end
          close = 1'b1;
        end else if (wi_q < SLOT_BYTES - 3) begin
          nbytes   = 2'd1;
          bytes[0] = item_i.data_byte;
          wi_d     = wi_q + IDX_W'(1);
        end else begin
          // The slot is about to overflow: drop the byte and close the line.
          nbytes   = 2'd3;
          bytes[0] = CH_CR;
          bytes[1] = CH_LF;
          bytes[2] = CH_NUL;
          dlen     = wi_ext + POS_W'(1);
          close    = 1'b1;
          trunc    = 1'b1;
        end
      end
      KIND_RELEASE: begin
        if (sel_ok && status_q[sel_slot] == ST_READY) begin
          status_d[sel_slot] = ST_EMPTY;
        end
      end
      KIND_TIMEOUT: begin
        wi_d = '0;
      end
      KIND_READ: begin
        if (sel_ok) begin
          res_o.read_status = status_q[sel_slot];
        end
      end
      default: begin
      end
    endcase

    if (close) begin
      status_d[cur_q] = ST_READY;
      status_d[nxt]   = ST_WRITING;
      cur_d           = nxt;
      wi_d            = '0;
      res_o.done_slot = 2'(cur_q);
    end
    res_o.line_done   = close;
    res_o.done_length = 7'(dlen);
    res_o.truncated   = trunc;
  end

  // Bank b takes the byte whose position in the slot is congruent to b.
  always_comb begin
    logic [BANK_W-1:0] k;
    logic [POS_W-1:0]  pos;
    for (int b = 0; b < BANKS; b++) begin
      k            = BANK_W'(b) - wi_q[BANK_W-1:0];
      pos          = wi_ext + POS_W'(k);
      wr_pos_o[b]  = pos;
      wr_en_o[b]   = step_i && (item_i.kind == KIND_BYTE) && (k < nbytes)
                     && (pos < SLOT_BYTES);
      case (k)
        2'd0:    wr_data_o[b] = bytes[0];
        2'd1:    wr_data_o[b] = bytes[1];
        2'd2:    wr_data_o[b] = bytes[2];
        default: wr_data_o[b] = CH_NUL;
      endcase
    end
  end

  assign wr_slot_o = cur_q;
  assign rd_ok_o   = (item_i.kind == KIND_READ) && sel_ok && off_ok;
  assign rd_slot_o = sel_slot;
  assign rd_pos_o  = POS_W'(item_i.byte_offset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '{default: ST_EMPTY};
      wi_q     <= '0;
      cur_q    <= '0;
    end else if (step_i) begin
      status_q <= status_d;
      wi_q     <= wi_d;
      cur_q    <= cur_d;
    end
  end

  a_wi_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wi_q <= SLOT_BYTES - 3)
    else $error("Write index passed the overflow threshold.");

  a_close_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && close |=> (status_q[cur_q] == ST_WRITING) && (wi_q == '0)
                        && (status_q[$past(cur_q)] == ST_READY))
    else $error("Closing a line did not advance to the next slot.");

  a_cur_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q[cur_q] != ST_READY)
    else $error("The slot being filled is marked ready.");

endmodule

`default_nettype wire

// ===== hdl/serial_line_slot_assembler.sv =====
`default_nettype none
// Each input beat is taken into the input register; its result is registered when the output can take it.
// Throughput: one beat per cycle while the output is ready; each beat is at most one write per bank.
// A stalled output holds one result while a further input beat waits in the input register.
// Reset: asynchronous, active low; slots empty, write index and current slot zero.
// After reset the line store clears its SLOT_COUNT * ceil(SLOT_BYTES / 4) rows
// (128 with the defaults), and no input beat is accepted until the clearing pass ends.

module serial_line_slot_assembler import slsa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int unsigned SLOT_BYTES = SLOT_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slsa_chan_if.sink  in_i,
  slsa_chan_if.source out_o
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned POS_W  = $clog2(SLOT_BYTES) + 1;

  in_beat_t                   in_q;
  logic                       in_valid_q;
  out_beat_t                  res_q;
  out_beat_t                  res;
  logic                       out_valid_q;
  logic                       busy;
  logic                       step;
  logic                       in_ready;
  logic [BANKS-1:0]           wr_en;
  logic [SLOT_W-1:0]          wr_slot;
  logic [BANKS-1:0][POS_W-1:0] wr_pos;
  logic [BANKS-1:0][7:0]      wr_data;
  logic                       rd_ok;
  logic [SLOT_W-1:0]          rd_slot;
  logic [POS_W-1:0]           rd_pos;
  logic [7:0]                 rd_data;

  assign step     = in_valid_q && (!out_valid_q || out_o.ready) && !busy;
  assign in_ready = !busy && (!in_valid_q || step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_ready) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      in_q <= in_i.payload;
    end
    if (step) begin
      res_q <= res;
    end
  end

  slsa_slot_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_q),
    .wr_en_o   (wr_en),
    .wr_slot_o (wr_slot),
    .wr_pos_o  (wr_pos),
    .wr_data_o (wr_data),
    .rd_ok_o   (rd_ok),
    .rd_slot_o (rd_slot),
    .rd_pos_o  (rd_pos),
    .res_o     (res)
  );

  slsa_line_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .wr_en_i   (wr_en),
    .wr_slot_i (wr_slot),
    .wr_pos_i  (wr_pos),
    .wr_data_i (wr_data),
    .rd_ok_i   (rd_ok),
    .rd_slot_i (rd_slot),
    .rd_pos_i  (rd_pos),
    .rd_data_o (rd_data),
    .busy_o    (busy)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;

  always_comb begin
    out_o.payload           = res_q;
    out_o.payload.read_data = rd_data;
  end

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready && !step)
    else $error("Input beat taken during the clearing pass.");

  a_held_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_q))
    else $error("Waiting input beat was lost or changed.");

  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("Processed beat produced no result.");

endmodule

`default_nettype wire

// ===== tb/line_scoreboard_pkg.sv =====
`default_nettype none

package line_scoreboard_pkg;

  import slsa_pkg::*;

  class line_scoreboard;

    logic [7:0] line_bytes [SLOT_COUNT_DEF * SLOT_BYTES_DEF];
    status_e    slot_state [SLOT_COUNT_DEF];
    int unsigned write_pos;
    int unsigned fill_slot;
    out_beat_t  awaited_results [$];
    int unsigned mismatches;

    function new();
      foreach (line_bytes[i]) line_bytes[i] = CH_NUL;
      foreach (slot_state[i]) slot_state[i] = ST_EMPTY;
      write_pos  = 0;
      fill_slot  = 0;
      mismatches = 0;
    endfunction

    function void put_byte(int unsigned slot, int unsigned pos, logic [7:0] value);
      if (slot < SLOT_COUNT_DEF && pos < SLOT_BYTES_DEF) begin
        line_bytes[slot * SLOT_BYTES_DEF + pos] = value;
      end
    endfunction

    // The filled slot becomes ready and the next slot in the ring is opened for writing.
    function int unsigned close_line();
      int unsigned closed;
      closed = fill_slot;
      slot_state[closed] = ST_READY;
      fill_slot = (closed + 1 >= SLOT_COUNT_DEF) ? 0 : closed + 1;
      write_pos = 0;
      slot_state[fill_slot] = ST_WRITING;
      return closed;
    endfunction

    function void record_input_beat(in_beat_t b);
      out_beat_t   res;
      int unsigned sel;
      int unsigned off;
      res = '0;
      sel = 32'(b.slot_select);
      off = 32'(b.byte_offset);
      case (b.kind)
        KIND_BYTE: begin
          if (b.data_byte == CH_LF) begin
            if (write_pos < SLOT_BYTES_DEF - 1) begin
              put_byte(fill_slot, write_pos, CH_LF);
              put_byte(fill_slot, write_pos + 1, CH_NUL);
              res.done_length = 7'(write_pos + 1);
            end else begin
              put_byte(fill_slot, write_pos, CH_NUL);
              res.done_length = 7'(write_pos);
            end
            res.line_done = 1'b1;
            res.done_slot = 2'(close_line());
          end else if (write_pos < SLOT_BYTES_DEF - 3) begin
            put_byte(fill_slot, write_pos, b.data_byte);
            write_pos++;
          end else begin
            put_byte(fill_slot, write_pos, CH_CR);
            put_byte(fill_slot, write_pos + 1, CH_LF);
            put_byte(fill_slot, write_pos + 2, CH_NUL);
            res.done_length = 7'(write_pos + 1);
            res.truncated   = 1'b1;
            res.line_done   = 1'b1;
            res.done_slot   = 2'(close_line());
          end
        end
        KIND_RELEASE: begin
          if (sel < SLOT_COUNT_DEF && slot_state[sel] == ST_READY) begin
            slot_state[sel] = ST_EMPTY;
          end
        end
        KIND_TIMEOUT: begin
          write_pos = 0;
        end
        KIND_READ: begin
          if (sel < SLOT_COUNT_DEF) begin
            res.read_status = slot_state[sel];
            if (off < SLOT_BYTES_DEF) begin
              res.read_data = line_bytes[sel * SLOT_BYTES_DEF + off];
            end
          end
        end
        default: begin
        end
      endcase
      awaited_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_output_beat(out_beat_t got);
      out_beat_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat %h arrived with nothing expected", $time, got);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("line_done", 8'(want.line_done), 8'(got.line_done));
      compare_field("done_slot", 8'(want.done_slot), 8'(got.done_slot));
      compare_field("done_length", 8'(want.done_length), 8'(got.done_length));
      compare_field("truncated", 8'(want.truncated), 8'(got.truncated));
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("read_status", 8'(want.read_status), 8'(got.read_status));
    endfunction

  endclass

endpackage

`default_nettype wire

// ===== tb/serial_line_slot_assembler_tb.sv =====
`default_nettype none

module serial_line_slot_assembler_tb import slsa_pkg::*, line_scoreboard_pkg::*; ();

  localparam int unsigned TOTAL_BEATS = 1050;
  localparam int unsigned STALL_LIMIT = 5000;

  logic        clk_i;
  logic        rst_ni;
  bit          steady = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned lines_sent = 0;
  int unsigned quiet_cycles = 0;
  line_scoreboard sb;

  slsa_chan_if #(.payload_t(in_beat_t))  in_if ();
  slsa_chan_if #(.payload_t(out_beat_t)) out_if ();

  serial_line_slot_assembler u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) sb.check_output_beat(out_if.payload);
    if (in_if.valid && in_if.ready) sb.record_input_beat(in_if.payload);
    if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_beat_t make_beat(kind_e k, logic [7:0] d, logic [1:0] s,
                                         logic [6:0] o);
    in_beat_t b;
    b.kind        = k;
    b.data_byte   = d;
    b.slot_select = s;
    b.byte_offset = o;
    return b;
  endfunction

  task automatic send_beat(in_beat_t b);
    while (!steady && $urandom_range(99) < 33) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= b;
    do @(posedge clk_i); while (!in_if.ready);
    beats_sent++;
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_line(int unsigned len);
    logic [7:0] d;
    for (int unsigned i = 0; i < len; i++) begin
      d = 8'($urandom_range(255));
      if (d == CH_LF) d = d ^ 8'h01;
      send_beat(make_beat(KIND_BYTE, d, 2'($urandom_range(3)), 7'($urandom_range(127))));
    end
    send_beat(make_beat(KIND_BYTE, CH_LF, 2'($urandom_range(3)), 7'($urandom_range(127))));
    lines_sent++;
  endtask

  task automatic send_noise();
    kind_e      k;
    logic [7:0] d;
    logic [6:0] o;
    k = kind_e'($urandom_range(3));
    d = ($urandom_range(9) == 0) ? CH_LF : 8'($urandom_range(255));
    o = $urandom_range(1) ? 7'($urandom_range(15)) : 7'($urandom_range(127));
    send_beat(make_beat(k, d, 2'($urandom_range(3)), o));
  endtask

  initial begin
    int unsigned line_len;
    bit          drained;
    drained        = 1'b0;
    sb             = new();
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(make_beat(KIND_READ, 8'h00, 2'd0, 7'd0));
    send_beat(make_beat(KIND_READ, 8'hFF, 2'd3, 7'd127));
    send_beat(make_beat(KIND_RELEASE, 8'h00, 2'd2, 7'd0));
    send_beat(make_beat(KIND_TIMEOUT, 8'h00, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, 8'hFF, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, 8'h00, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, CH_CR, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, 8'h80, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, 8'h55, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, 8'hAA, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, 8'h7F, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, CH_LF, 2'd0, 7'd0));
    send_beat(make_beat(KIND_READ, 8'h00, 2'd0, 7'd7));
    send_beat(make_beat(KIND_READ, 8'h00, 2'd0, 7'd8));
    send_beat(make_beat(KIND_READ, 8'h00, 2'd1, 7'd0));
    send_beat(make_beat(KIND_RELEASE, 8'h00, 2'd1, 7'd0));
    send_beat(make_beat(KIND_RELEASE, 8'h00, 2'd0, 7'd0));
    send_beat(make_beat(KIND_READ, 8'h00, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, 8'h61, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, 8'h62, 2'd0, 7'd0));
    send_beat(make_beat(KIND_TIMEOUT, 8'h00, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, 8'h63, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, CH_LF, 2'd0, 7'd0));
    send_beat(make_beat(KIND_BYTE, CH_LF, 2'd0, 7'd0));
    send_beat(make_beat(KIND_READ, 8'h00, 2'd1, 7'd0));

    // Mostly complete lines with random content; the third may overflow its slot.
    while (beats_sent < TOTAL_BEATS) begin
      steady = (beats_sent >= 700 && beats_sent < 850);
      if (!drained && beats_sent >= 500) begin
        wait_for_results();
        drained = 1'b1;
      end
      if ($urandom_range(9) < 7) begin
        line_len = (lines_sent == 2 || $urandom_range(19) == 0) ?
                   $urandom_range(135, 120) : $urandom_range(12);
        send_line(line_len);
        if ($urandom_range(1)) begin
          send_beat(make_beat(KIND_RELEASE, 8'h00, 2'($urandom_range(3)), 7'd0));
        end
        if ($urandom_range(1)) begin
          send_beat(make_beat(KIND_READ, 8'h00, 2'($urandom_range(3)),
                              7'($urandom_range(15))));
        end
      end else begin
        send_noise();
      end
    end

    wait_for_results();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
